>>> hdl/ts_info_descriptor_parser_macros.svh
// ----------------------------------------------------------------------------
// TS information descriptor parser assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TS_INFO_DESCRIPTOR_PARSER_MACROS_SVH
`define TS_INFO_DESCRIPTOR_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsid assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TSID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsid assertion failed: next-cycle implication");

`endif

>>> hdl/tsid_pkg.sv
// ----------------------------------------------------------------------------
// TS information descriptor parser package
// Result kinds, the parsed word type and queue sizing shared by all modules.
// ----------------------------------------------------------------------------
package tsid_pkg;

    // Kind of a parsed field, carried on the result tuser.
    typedef enum logic [2:0] {
        KIND_KEY    = 3'd0,
        KIND_HEADER = 3'd1,
        KIND_NAME   = 3'd2,
        KIND_TYPE   = 3'd3,
        KIND_COUNT  = 3'd4,
        KIND_SVC    = 3'd5
    } t_item_kind;

    // One parsed field as it travels from the parser to the output stage.
    typedef struct packed {
        t_item_kind  kind;
        logic [15:0] value;
        logic [1:0]  type_index;
        logic        last;
    } t_tsid_item;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

endpackage

>>> hdl/tsid_front.sv
// ----------------------------------------------------------------------------
// TS information descriptor parser front end
// Walks the descriptor layout one byte per cycle while bytes are accepted and classifies each byte.
// ----------------------------------------------------------------------------
module tsid_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_first,
    output logic                 o_push,
    output tsid_pkg::t_tsid_item o_item
);
    import tsid_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_NAME,
        PH_TYPE,
        PH_COUNT,
        PH_SVC_HI,
        PH_SVC_LO
    } t_phase;

    t_phase     r_phase,    n_phase;
    logic [5:0] r_name_left, n_name_left;
    logic [1:0] r_types_left, n_types_left;
    logic [7:0] r_svc_left, n_svc_left;
    logic [7:0] r_hold,     n_hold;
    logic [1:0] r_group,    n_group;

    always_comb begin
        n_phase      = r_phase;
        n_name_left  = r_name_left;
        n_types_left = r_types_left;
        n_svc_left   = r_svc_left;
        n_hold       = r_hold;
        n_group      = r_group;
        o_push       = 1'b0;
        o_item       = '{kind: KIND_KEY, value: {8'h00, i_byte}, type_index: 2'd0,
                         last: 1'b0};

        if (i_accept) begin
            if (i_first) begin
                // A first byte always opens a new descriptor.
                n_name_left  = 6'd0;
                n_types_left = 2'd0;
                n_svc_left   = 8'd0;
                n_hold       = 8'd0;
                n_group      = 2'd0;
                n_phase      = PH_HEADER;
                o_push       = 1'b1;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_name_left  = i_byte[7:2];
                        n_types_left = i_byte[1:0];
                        n_group      = 2'd0;
                        o_push       = 1'b1;
                        o_item.kind  = KIND_HEADER;
                        if (i_byte == 8'h00) begin
                            n_phase     = PH_IDLE;
                            o_item.last = 1'b1;
                        end else if (i_byte[7:2] != 6'd0) begin
                            n_phase = PH_NAME;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_NAME: begin
                        n_name_left = r_name_left - 6'd1;
                        o_push      = 1'b1;
                        o_item.kind = KIND_NAME;
                        if (r_name_left == 6'd1) begin
                            if (r_types_left == 2'd0) begin
                                n_phase     = PH_IDLE;
                                o_item.last = 1'b1;
                            end else begin
                                n_phase = PH_TYPE;
                            end
                        end
                    end
                    PH_TYPE: begin
                        n_phase           = PH_COUNT;
                        o_push            = 1'b1;
                        o_item.kind       = KIND_TYPE;
                        o_item.type_index = r_group;
                    end
                    PH_COUNT: begin
                        n_svc_left        = i_byte;
                        o_push            = 1'b1;
                        o_item.kind       = KIND_COUNT;
                        o_item.type_index = r_group;
                        if (i_byte == 8'h00) begin
                            // Empty group closes at once.
                            n_types_left = r_types_left - 2'd1;
                            n_group      = r_group + 2'd1;
                            o_item.last  = (r_types_left == 2'd1);
                            n_phase      = (r_types_left == 2'd1) ? PH_IDLE : PH_TYPE;
                        end else begin
                            n_phase = PH_SVC_HI;
                        end
                    end
                    PH_SVC_HI: begin
                        n_hold  = i_byte;
                        n_phase = PH_SVC_LO;
                    end
                    PH_SVC_LO: begin
                        n_svc_left        = r_svc_left - 8'd1;
                        o_push            = 1'b1;
                        o_item.kind       = KIND_SVC;
                        o_item.value      = {r_hold, i_byte};
                        o_item.type_index = r_group;
                        if (r_svc_left == 8'd1) begin
                            n_types_left = r_types_left - 2'd1;
                            n_group      = r_group + 2'd1;
                            o_item.last  = (r_types_left == 2'd1);
                            n_phase      = (r_types_left == 2'd1) ? PH_IDLE : PH_TYPE;
                        end else begin
                            n_phase = PH_SVC_HI;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_name_left  <= 6'd0;
            r_types_left <= 2'd0;
            r_svc_left   <= 8'd0;
            r_hold       <= 8'd0;
            r_group      <= 2'd0;
        end else begin
            r_phase      <= n_phase;
            r_name_left  <= n_name_left;
            r_types_left <= n_types_left;
            r_svc_left   <= n_svc_left;
            r_hold       <= n_hold;
            r_group      <= n_group;
        end
    end

endmodule

>>> hdl/tsid_fifo.sv
// ----------------------------------------------------------------------------
// TS information descriptor parser field queue
// Short queue of parsed fields between the parser and the output stage.
// ----------------------------------------------------------------------------
module tsid_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tsid_pkg::t_tsid_item i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output tsid_pkg::t_tsid_item o_item
);
    import tsid_pkg::*;

    t_tsid_item         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               do_pop;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/tsid_back.sv
// ----------------------------------------------------------------------------
// TS information descriptor parser output stage
// Registers one queued field onto the master stream and holds it on stall.
// ----------------------------------------------------------------------------
module tsid_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  tsid_pkg::t_tsid_item           i_item,
    output logic                           o_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [tsid_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import tsid_pkg::*;

    logic       r_valid;
    t_tsid_item r_item;

    // Take a new field whenever the output register is empty or being drained.
    assign o_pop = i_valid && (!r_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'd0, r_item.type_index, r_item.value};
    assign m_axis_tuser  = r_item.kind;
    assign m_axis_tlast  = r_item.last;

endmodule

>>> hdl/ts_info_descriptor_parser.sv
// ----------------------------------------------------------------------------
// TS information descriptor parser
// Splits an information descriptor payload into tagged fields.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one payload byte per word in s_axis_tdata, with
//   s_axis_tuser high on the first byte of each descriptor. The master stream
//   gives one word per parsed field: field value and type group in tdata,
//   field kind in tuser, and tlast on the final field of the descriptor.
//   The high byte of a service id gives no word; the low byte gives the id.
//   Bytes outside an open descriptor are taken and dropped.
//   Throughput is one byte per cycle while the field queue is not full. Each
//   field word is written into the field queue and then loaded into the
//   output register before it shows on the master side.
//   s_axis_tready falls only when the four-entry field queue is full, so the
//   parser keeps taking bytes while a word waits on a stalled receiver; a
//   long stall fills the queue and then backpressures the input.
//   Synchronous reset clears the parser to idle, empties the queue and drops
//   the output word; bytes after reset are dropped until one has the flag.
// ----------------------------------------------------------------------------
module ts_info_descriptor_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tsid_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] payload_byte
    input  logic                             s_axis_tuser,  // [0] first_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tsid_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] field_value,
                                                            // [17:16] type_index,
                                                            // [23:18] zero
    output logic [2:0]                       m_axis_tuser,  // [2:0] item_kind
    output logic                             m_axis_tlast   // last_field
);
    import tsid_pkg::*;

    logic       accept;
    logic       push;
    t_tsid_item front_item;
    logic       fifo_full;
    logic       fifo_valid;
    t_tsid_item fifo_item;
    logic       pop;

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && !fifo_full;

    // Parser: keeps the descriptor position and classifies every byte.
    tsid_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_first  (s_axis_tuser),
        .o_push   (push),
        .o_item   (front_item)
    );

    // Field queue decouples parsing from receiver stalls.
    tsid_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_item  (fifo_item)
    );

    // Output register onto the master stream.
    tsid_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (fifo_valid),
        .i_item        (fifo_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> hdl/tsid_checker.sv
// ----------------------------------------------------------------------------
// TS information descriptor parser port checker
// Watches the top-level ports for stream and field-format slips.
// ----------------------------------------------------------------------------
`include "ts_info_descriptor_parser_macros.svh"

module tsid_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tsid_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]                       m_axis_tuser,
    input logic                             m_axis_tlast
);
    import tsid_pkg::*;

    // A stalled word stays up.
    `TSID_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Only header, name, count and service id fields can close a descriptor.
    `TSID_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, (m_axis_tuser != KIND_KEY) && (m_axis_tuser != KIND_TYPE))

    // Fields before the type groups carry group zero.
    `TSID_ASSERT_NOW(a_group_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_KEY || m_axis_tuser == KIND_HEADER || m_axis_tuser == KIND_NAME), m_axis_tdata[17:16] == 2'd0)

    // Only a service id fills the upper value byte.
    `TSID_ASSERT_NOW(a_byte_value, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != KIND_SVC), m_axis_tdata[15:8] == 8'h00)

endmodule

bind ts_info_descriptor_parser tsid_checker u_tsid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
